// File: src/mck_pkg.sv
package mck_pkg;

  localparam int QueueDepth = 4;
  localparam int QueueIdxW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [2:0] UNITS_DOT       = 3'd1;
  localparam logic [2:0] UNITS_DASH      = 3'd3;
  localparam logic [2:0] UNITS_GAP       = 3'd1;
  localparam logic [2:0] UNITS_CHAR_GAP  = 3'd3;
  localparam logic [2:0] UNITS_WORD_GAP  = 3'd5;

  localparam logic [15:0] UNIT_LENGTH_RESET = 16'd125;

  // Symbol patterns are written in sending order from the MSB down; a 1 is a dash.
  localparam logic [4:0] LETTER_DASH [26] = '{
    5'b01000, 5'b10000, 5'b10100, 5'b10000, 5'b00000, 5'b00100, 5'b11000,
    5'b00000, 5'b00000, 5'b01110, 5'b10100, 5'b01000, 5'b11000, 5'b10000,
    5'b11100, 5'b01100, 5'b11010, 5'b01000, 5'b00000, 5'b10000, 5'b00100,
    5'b00010, 5'b01100, 5'b10010, 5'b10110, 5'b11000
  };
  localparam logic [2:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [4:0] DIGIT_DASH [10] = '{
    5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
    5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
  };
  localparam logic [2:0] DIGIT_LEN = 3'd5;

  // One queued character. A space has no symbols.
  typedef struct packed {
    logic       is_space;
    logic [2:0] len;
    logic [4:0] dashes;
  } char_entry_t;

endpackage

// File: src/mck_front.sv
module mck_front
  import mck_pkg::*;
(
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        q_full,
  output logic        q_push,
  output char_entry_t q_entry
);

  logic       known;
  logic [4:0] letter_idx;
  logic [3:0] digit_idx;

  assign letter_idx = 5'(s_axis_tdata - CHAR_A);
  assign digit_idx  = 4'(s_axis_tdata - CHAR_0);

  always_comb begin
    known   = 1'b0;
    q_entry = '0;
    if (s_axis_tdata == CHAR_SPACE) begin
      known            = 1'b1;
      q_entry.is_space = 1'b1;
    end else if (s_axis_tdata inside {[CHAR_A:CHAR_Z]}) begin
      known          = 1'b1;
      q_entry.len    = LETTER_LEN[letter_idx];
      q_entry.dashes = LETTER_DASH[letter_idx];
    end else if (s_axis_tdata inside {[CHAR_0:CHAR_9]}) begin
      known          = 1'b1;
      q_entry.len    = DIGIT_LEN;
      q_entry.dashes = DIGIT_DASH[digit_idx];
    end
  end

  // Characters without a code are taken and dropped here.
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && known;

endmodule

// File: src/mck_queue.sv
module mck_queue
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  char_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output char_entry_t head_entry
);

  char_entry_t             slots [QueueDepth];
  logic [QueueIdxW-1:0]    wr_ptr;
  logic [QueueIdxW-1:0]    rd_ptr;
  logic [QueueCntW-1:0]    count;
  logic                    do_pop;

  assign full       = (count == QueueCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/mck_back.sv
module mck_back
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        head_valid,
  input  char_entry_t head_entry,
  output logic        pop,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [15:0] unit_length;
  logic [3:0]  step;
  logic        advance;
  logic        is_final;
  logic        on_seg;
  logic [2:0]  sym;
  logic [4:0]  shifted;
  logic [2:0]  units;
  logic [18:0] ticks;

  logic        key_on;
  logic [2:0]  length_units;
  logic [18:0] length_ticks;

  // Steps run on, off for each symbol, then the closing gap.
  assign is_final = (step == {head_entry.len, 1'b0});
  assign on_seg   = !step[0] && !is_final;
  assign sym      = step[3:1];
  assign shifted  = head_entry.dashes << sym;

  always_comb begin
    if (is_final) begin
      units = head_entry.is_space ? UNITS_WORD_GAP : UNITS_CHAR_GAP;
    end else if (on_seg) begin
      units = shifted[4] ? UNITS_DASH : UNITS_DOT;
    end else begin
      units = UNITS_GAP;
    end
  end

  assign ticks   = 19'(units) * 19'(unit_length);
  assign advance = head_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop     = advance && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_length <= UNIT_LENGTH_RESET;
    end else if (cfg_we) begin
      unit_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        step          <= is_final ? 4'd0 : step + 4'd1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_on       <= on_seg;
      length_units <= units;
      length_ticks <= ticks;
      m_axis_tlast <= is_final;
    end
  end

  assign m_axis_tdata = {1'b0, length_ticks, length_units, key_on};

endmodule

// File: src/morse_character_keyer_top.sv
// Morse keyer: each accepted ASCII beat (space, A to Z, 0 to 9) becomes a run
// of key segments, one output beat per segment, the last one marked by tlast.
// Other codes are accepted and produce nothing. An n-symbol character gives
// 2n+1 segments and a space gives one, so a character gives 1 to 11 segments;
// the segment sequencer emits one segment per clock unless the queue is empty or
// the output stalls. A four-entry queue sits between the input classifier and
// the sequencer, so new characters are taken while earlier ones are still
// being sent. length_ticks is length_units times unit_length, written via cfg_we.
module morse_character_keyer_top
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // unit_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] key_on, [3:1] length_units, [22:4] length_ticks
  output logic        m_axis_tlast    // last_segment
);

  logic        q_full;
  logic        q_push;
  char_entry_t q_entry;
  logic        q_pop;
  logic        q_head_valid;
  char_entry_t q_head;

  mck_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  mck_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  mck_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head_valid    (q_head_valid),
    .head_entry    (q_head),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: bench/morse_character_keyer_top_tb.sv
module morse_character_keyer_top_tb;
  import mck_pkg::*;

  localparam logic [7:0]  ASCII_SPACE   = 8'h20;
  localparam logic [15:0] UNIT_AT_RESET = 16'd125;
  localparam int          DRAIN_CYCLES  = 24;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_PHASES = 5;
  localparam int          CHARS_PER_PHASE = 40;

  typedef struct packed {
    logic        key_on;
    logic [2:0]  units;
    logic [18:0] ticks;
    logic        last;
  } segment_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  segment_t    pending_segments[$];
  logic [15:0] unit_len_model = UNIT_AT_RESET;
  int          errors = 0;
  int          chars_sent = 0;
  int          keyed_chars = 0;
  int          segments_checked = 0;
  int          unit_settings = 1;
  int          cycle_count = 0;
  bit          tx_burst = 1'b0;
  bit          rx_quiet = 1'b0;
  int          hold_req = 0;
  int          stall_left = 0;

  morse_character_keyer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d segments outstanding", $time, pending_segments.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Dots and dashes for each letter and digit the keyer knows; empty for anything else, a space included.
  function automatic string morse_pattern(input logic [7:0] c);
    case (c)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  function automatic void queue_segment(input logic on, input logic [2:0] units,
                                        input logic last);
    segment_t seg;
    logic [31:0] product;
    product    = 32'(units) * 32'(unit_len_model);
    seg.key_on = on;
    seg.units  = units;
    seg.ticks  = product[18:0];
    seg.last   = last;
    pending_segments.push_back(seg);
  endfunction

  function automatic void predict_segments(input logic [7:0] c);
    string pattern;
    int i;
    if (c == ASCII_SPACE) begin
      queue_segment(1'b0, 3'd5, 1'b1);
      keyed_chars++;
      return;
    end
    pattern = morse_pattern(c);
    if (pattern.len() == 0)
      return;
    keyed_chars++;
    for (i = 0; i < pattern.len(); i++) begin
      queue_segment(1'b1, (pattern[i] == "-") ? 3'd3 : 3'd1, 1'b0);
      queue_segment(1'b0, 3'd1, 1'b0);
    end
    queue_segment(1'b0, 3'd3, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_burst)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      r = $urandom_range(0, 36);
      if (r == 36)
        return ASCII_SPACE;
      if (r >= 26)
        return 8'("0" + r - 26);
      return 8'("A" + r);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    chars_sent++;
    predict_segments(c);
  endtask

  // The sender stops and waits until the keyer has emitted everything.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_segments.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_unit_length(input logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 16'($urandom);
    unit_len_model = value;
    unit_settings++;
  endtask

  task automatic test_directed_chars();
    logic [7:0] chars[16];
    chars = '{ASCII_SPACE, "A", "E", "T", "Z", "0", "5", "9",
              "/", ":", "@", "[", "a", 8'h00, 8'h80, 8'hFF};
    foreach (chars[i])
      send_char(chars[i]);
  endtask

  // Smallest, largest and zero unit lengths, with the shortest and longest characters.
  task automatic test_unit_extremes();
    logic [15:0] units[3];
    units = '{16'd1, 16'hFFFF, 16'd0};
    foreach (units[i]) begin
      set_unit_length(units[i]);
      send_char(ASCII_SPACE);
      send_char("0");
      send_char("E");
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] units[RANDOM_PHASES];
    int start;
    units = '{16'($urandom_range(2, 65534)), 16'd1, 16'hFFFF,
              16'($urandom_range(2, 1000)), UNIT_AT_RESET};
    foreach (units[p]) begin
      set_unit_length(units[p]);
      start = keyed_chars;
      while (keyed_chars - start < CHARS_PER_PHASE) begin
        if (chars_sent % 20 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        send_char(pick_char());
      end
    end
    tx_burst = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // The output side stops for a long time while characters keep coming, so the
  // internal queue fills and the input must stall.
  task automatic test_output_hold();
    int i;
    set_unit_length(16'($urandom_range(1, 65535)));
    tx_burst = 1'b1;
    hold_req = 400;
    for (i = 0; i < 24; i++)
      send_char((i % 3 == 0) ? pick_char() : 8'("0" + i % 10));
    tx_burst = 1'b0;
  endtask

  always @(negedge clk) begin
    int r;
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (rx_quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
      end
    end
  end

  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.key_on = m_axis_tdata[0];
      got.units  = m_axis_tdata[3:1];
      got.ticks  = m_axis_tdata[22:4];
      got.last   = m_axis_tlast;
      if (pending_segments.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment on=%0d units=%0d ticks=%0d last=%0d",
                 $time, got.key_on, got.units, got.ticks, got.last);
      end else begin
        want = pending_segments.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: segment %0d expected on=%0d units=%0d ticks=%0d last=%0d",
                   $time, segments_checked, want.key_on, want.units, want.ticks, want.last);
          $display("%0t: segment %0d actual   on=%0d units=%0d ticks=%0d last=%0d",
                   $time, segments_checked, got.key_on, got.units, got.ticks, got.last);
        end
      end
      segments_checked++;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_chars();
    test_unit_extremes();
    test_random_traffic();
    test_output_hold();
    wait_drained();

    $display("Sent %0d characters (%0d keyed), checked %0d segments under %0d unit lengths,",
             chars_sent, keyed_chars, segments_checked, unit_settings);
    $display("including zero and full-scale units and a long output stall.");
    if (errors == 0 && pending_segments.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: morse_character_keyer_top.f
src/mck_pkg.sv
src/mck_front.sv
src/mck_queue.sv
src/mck_back.sv
src/morse_character_keyer_top.sv
bench/morse_character_keyer_top_tb.sv
